### src/upd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_pkg - URL percent decoder package
// Word types, character constants, escape phase codes and the hex digit
// decode shared by the front, the queue and the back of the decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [3:0] HEX_TEN    = 4'd10;

    // escape phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PCT   = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    // most words one input word can expand into
    localparam int MAX_RES = 3;

    // default depth of the queue between front and back
    localparam int QDEPTH_DEF = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out;

    // one classified input word: up to three result bytes, oldest in slot 0
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [1:0]              cnt;
        logic                    last;
    } t_bundle;

    // queue head as seen by the back
    typedef struct packed {
        logic    empty;
        t_bundle head;
    } t_q_rd;

    // {valid, value}; valid low when c is not a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= 8'h30 && c <= 8'h39) begin
                d = c - 8'h30;
                hex_val = {1'b1, d[3:0]};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                d = c - 8'h41;
                hex_val = {1'b1, d[3:0] + HEX_TEN};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                d = c - 8'h61;
                hex_val = {1'b1, d[3:0] + HEX_TEN};
            end else begin
                hex_val = 5'b0_0000;
            end
        end
    endfunction

endpackage

### src/upd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_front - decoder front end
// Takes one encoded word, tracks the escape state and classifies the word
// into a bundle of zero to three decoded bytes for the queue.
// ----------------------------------------------------------------------------
module upd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  upd_pkg::t_in     i_in,
    output logic             o_bundle_vld,
    output upd_pkg::t_bundle o_bundle
);

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_held, n_held;

    always_comb begin
        logic [upd_pkg::MAX_RES-1:0][7:0] slots;
        logic [1:0] cnt;
        logic [4:0] hv;
        logic [4:0] hh;
        logic       do_plain;
        logic [7:0] c;

        c        = i_in.in_byte;
        hv       = upd_pkg::hex_val(c);
        hh       = upd_pkg::hex_val(r_held);
        slots    = '0;
        cnt      = 2'd0;
        do_plain = 1'b0;
        n_phase  = r_phase;
        n_held   = r_held;

        unique case (r_phase)
            upd_pkg::PH_PCT: begin
                if (hv[4]) begin
                    n_held  = c;
                    n_phase = upd_pkg::PH_DIGIT;
                end else begin
                    n_phase  = upd_pkg::PH_IDLE;
                    slots[0] = upd_pkg::CH_PERCENT;
                    cnt      = 2'd1;
                    do_plain = 1'b1;
                end
            end
            upd_pkg::PH_DIGIT: begin
                n_phase = upd_pkg::PH_IDLE;
                if (hv[4]) begin
                    slots[0] = {hh[3:0], hv[3:0]};
                    cnt      = 2'd1;
                end else begin
                    slots[0] = upd_pkg::CH_PERCENT;
                    slots[1] = r_held;
                    cnt      = 2'd2;
                    do_plain = 1'b1;
                end
            end
            default: begin
                n_phase  = upd_pkg::PH_IDLE;
                do_plain = 1'b1;
            end
        endcase

        // rejected digits fall back to ordinary handling
        if (do_plain) begin
            if (c == upd_pkg::CH_PERCENT) begin
                n_phase = upd_pkg::PH_PCT;
            end else if (cnt < 2'd3) begin
                slots[cnt] = (c == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : c;
                cnt        = cnt + 2'd1;
            end
        end

        // end of string: flush an unfinished escape literally
        if (i_in.in_last) begin
            if (n_phase == upd_pkg::PH_PCT || n_phase == upd_pkg::PH_DIGIT) begin
                if (cnt < 2'd3) begin
                    slots[cnt] = upd_pkg::CH_PERCENT;
                    cnt        = cnt + 2'd1;
                end
            end
            if (n_phase == upd_pkg::PH_DIGIT) begin
                if (cnt < 2'd3) begin
                    slots[cnt] = n_held;
                    cnt        = cnt + 2'd1;
                end
            end
            n_phase = upd_pkg::PH_IDLE;
            n_held  = 8'h00;
        end

        o_bundle.bytes = slots;
        o_bundle.cnt   = cnt;
        o_bundle.last  = i_in.in_last;
        o_bundle_vld   = i_accept && (cnt != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= upd_pkg::PH_IDLE;
            r_held  <= 8'h00;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

### src/upd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_queue - bundle queue
// Short first-in first-out store of classified bundles between the front
// and the back, so each side can stall on its own.
// ----------------------------------------------------------------------------
module upd_queue #(
    parameter int DEPTH = upd_pkg::QDEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  upd_pkg::t_bundle i_bundle,
    input  logic             i_pop,
    output logic             o_full,
    output upd_pkg::t_q_rd   o_rd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    upd_pkg::t_bundle mem [DEPTH];

    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wr] <= i_bundle;
        end
    end

    assign o_full     = (r_cnt == CW'(DEPTH));
    assign o_rd.empty = (r_cnt == '0);
    assign o_rd.head  = mem[r_rd];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("bundle queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_rd.empty)
        else $error("bundle queue read while empty");

    a_no_empty_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (i_bundle.cnt != 2'd0))
        else $error("bundle with no bytes queued");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("bundle queue fill count out of range");

endmodule

### src/upd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_back - decoder back end
// Walks the bytes of the queue head bundle one per cycle into the output
// register while it is empty or popped, marking a string's final byte.
// ----------------------------------------------------------------------------
module upd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  upd_pkg::t_q_rd i_rd,
    output logic           o_q_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output upd_pkg::t_out  o_out
);

    logic [1:0]    r_idx, n_idx;
    logic          r_vld, n_vld;
    upd_pkg::t_out r_out, n_out;
    logic          load, take, end_of_bundle;

    assign load          = !r_vld || i_pop;
    assign take          = load && !i_rd.empty;
    assign end_of_bundle = ((r_idx + 2'd1) == i_rd.head.cnt);

    always_comb begin
        n_idx    = r_idx;
        n_vld    = r_vld;
        n_out    = r_out;
        o_q_pop  = 1'b0;
        if (load) begin
            n_vld = take;
        end
        if (take) begin
            n_out.out_byte = i_rd.head.bytes[r_idx];
            n_out.out_last = i_rd.head.last && end_of_bundle;
            if (end_of_bundle) begin
                n_idx   = 2'd0;
                o_q_pop = 1'b1;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
            r_vld <= 1'b0;
        end else begin
            r_idx <= n_idx;
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_empty = !r_vld;
    assign o_out   = r_out;

    a_idx_in_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rd.empty |-> (r_idx < i_rd.head.cnt))
        else $error("byte index beyond the head bundle");

    a_idx_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd.empty |-> (r_idx == 2'd0))
        else $error("byte index not cleared with queue empty");

endmodule

### src/url_percent_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder - URL percent decoder, top level
// Decodes %XX escapes and '+' in a byte stream with an end-of-string mark.
//
//   channel   direction  handshake               word
//   input     in         push / full             t_in  {in_byte, in_last}
//   result    out        empty / pop             t_out {out_byte, out_last}
//
// One input word is taken per cycle while the bundle queue has room; one
// result word leaves per cycle from the output register while pop is high.
// An input word expands into zero to three result words, so a run of
// expanding words fills the queue and raises full until the back catches up.
// With nothing waiting ahead of it, an input word's first result word goes
// into the queue memory, then into the output register on the result ports.
// Reset is synchronous and active low; it clears the escape state, the
// queue pointers and the output valid flag.
// ----------------------------------------------------------------------------
module url_percent_decoder #(
    parameter int QDEPTH = upd_pkg::QDEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  upd_pkg::t_in  i_data,
    output logic          empty,
    input  logic          pop,
    output upd_pkg::t_out o_data
);

    logic             accept;
    logic             bundle_vld;
    upd_pkg::t_bundle bundle;
    logic             q_full;
    logic             q_pop;
    upd_pkg::t_q_rd   q_rd;

    assign accept = push && !q_full;
    assign full   = q_full;

    upd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_in         (i_data),
        .o_bundle_vld (bundle_vld),
        .o_bundle     (bundle)
    );

    upd_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (bundle_vld),
        .i_bundle (bundle),
        .i_pop    (q_pop),
        .o_full   (q_full),
        .o_rd     (q_rd)
    );

    upd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (q_rd),
        .o_q_pop (q_pop),
        .i_pop   (pop),
        .o_empty (empty),
        .o_out   (o_data)
    );

endmodule
